>>> hdl/lavm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lavm_pkg;

   // Port widths
   localparam int WORD_W     = 32;
   localparam int DIFF_W     = WORD_W + 1;
   localparam int REQ_DATA_W = 6 * WORD_W;
   localparam int RSP_DATA_W = 3 * WORD_W;
   localparam int RSP_USER_W = 3;
   localparam int CSR_IDX_W  = 2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_UP_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UP_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UP_Z = 2'd2;

   // Up vector after reset: (0, 1.0, 0) in Q16.16
   localparam logic [WORD_W-1:0] UP_X_RESET = 32'h0000_0000;
   localparam logic [WORD_W-1:0] UP_Y_RESET = 32'h0001_0000;
   localparam logic [WORD_W-1:0] UP_Z_RESET = 32'h0000_0000;

   // Row codes
   localparam logic [1:0] ROW_RIGHT = 2'd0;
   localparam logic [1:0] ROW_TRANS = 2'd3;

   // One camera job waiting for the core
   typedef struct packed {
      logic [2:0][WORD_W-1:0] eye;
      logic [2:0][DIFF_W-1:0] diff;
   } job_type;

   // One finished matrix: rows 0..2 axes, row 3 translation
   typedef struct packed {
      logic [3:0][2:0][WORD_W-1:0] row;
      logic                        deg;
   } matrix_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ABS,
      ST_SCALE,
      ST_SQ,
      ST_SQRT,
      ST_DLD,
      ST_DIV,
      ST_X1,
      ST_X2,
      ST_DOT,
      ST_FIN
   } core_state_type;

endpackage

`default_nettype wire

>>> hdl/lavm_front.sv
`timescale 1ns / 1ps
`default_nettype none

module lavm_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [lavm_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                                job_valid,
   input  wire logic                           job_pop,
   output lavm_pkg::job_type                   job
);
   import lavm_pkg::*;

   job_type    mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push;
   job_type    entry;

   // Form the eye-minus-target difference on the way in
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         entry.eye[i]  = req_tdata[i*WORD_W +: WORD_W];
         entry.diff[i] = {req_tdata[i*WORD_W + WORD_W-1], req_tdata[i*WORD_W +: WORD_W]}
                       - {req_tdata[(i+3)*WORD_W + WORD_W-1],
                          req_tdata[(i+3)*WORD_W +: WORD_W]};
      end
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign job_valid  = (count_ff != 2'd0);
   assign job        = mem_ff[rd_ptr_ff];

   // Write the queue entry
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= entry;
      end
   end

   // Advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (job_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, job_pop};
      end
   end

endmodule

`default_nettype wire

>>> hdl/lavm_core.sv
`timescale 1ns / 1ps
`default_nettype none

module lavm_core #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       job_valid,
   output logic                            job_pop,
   input  wire lavm_pkg::job_type          job,
   input  wire logic [lavm_pkg::WORD_W-1:0] up_x,
   input  wire logic [lavm_pkg::WORD_W-1:0] up_y,
   input  wire logic [lavm_pkg::WORD_W-1:0] up_z,
   output logic                            mat_valid,
   input  wire logic                       mat_ready,
   output lavm_pkg::matrix_type            mat
);
   import lavm_pkg::*;

   localparam int AW = FRAC_BITS + 2;   // axis element, signed
   localparam int QW = FRAC_BITS + 1;   // quotient magnitude
   localparam int VW = FRAC_BITS + 35;  // vector before normalizing, signed
   localparam int NW = FRAC_BITS + 32;  // divider remainder
   localparam int DW = FRAC_BITS + 37;  // dot product, signed
   localparam int KW = $clog2(FRAC_BITS + 1);
   localparam int SW = 62;              // sum of squares and root search

   function automatic logic signed [32:0] ax33(input logic signed [AW-1:0] v);
      return 33'(v);
   endfunction

   core_state_type state_ff, state_in, after_norm;

   logic                   deg_ff;
   logic [1:0]             tgt_ff;
   logic [WORD_W-1:0]      eye_ff  [3];
   logic signed [VW-1:0]   vec_ff  [3];
   logic [VW-1:0]          mag_ff  [3];
   logic                   neg_ff  [3];
   logic signed [AW-1:0]   axis_ff [3][3];
   logic signed [DW-1:0]   dot_ff  [3];
   logic [SW-1:0]          sum_ff, root_ff, bit_ff;
   logic [30:0]            len_ff;
   logic [NW-1:0]          rem_ff;
   logic [QW-1:0]          q_ff;
   logic [KW-1:0]          k_ff;
   logic [1:0]             c_ff, j_ff;
   logic                   ph_ff;
   logic signed [65:0]     prod_ff;

   logic                   vec_zero, in_range, hi8, hi1, lo8, lo1;
   logic [VW-1:0]          mx;
   logic [SW-1:0]          sq_t, root_nx;
   logic                   sq_ge;
   logic [NW-1:0]          dsh;
   logic                   div_ge;
   logic [QW-1:0]          q_nx;
   logic signed [AW-1:0]   q_signed;
   logic signed [32:0]     opa, opb;
   logic signed [32:0]     xa [3];
   logic signed [32:0]     xb [3];
   logic signed [32:0]     ra [3];
   logic                   sq_last, x_last, dot_last;
   logic [WORD_W-1:0]      trans [3];

   // Status of the vector being normalized
   always_comb begin
      vec_zero = (vec_ff[0] == '0) && (vec_ff[1] == '0) && (vec_ff[2] == '0);
      mx = mag_ff[0];
      if (mag_ff[1] > mx) mx = mag_ff[1];
      if (mag_ff[2] > mx) mx = mag_ff[2];
      hi8      = |mx[VW-1:38];
      hi1      = |mx[VW-1:30];
      lo8      = ~|mx[VW-1:21];
      lo1      = ~hi1 && !mx[29];
      in_range = ~hi1 && mx[29];
   end

   // Root search step and divider step
   always_comb begin
      sq_t    = root_ff + bit_ff;
      sq_ge   = (sum_ff >= sq_t);
      root_nx = sq_ge ? ((root_ff >> 1) + bit_ff) : (root_ff >> 1);
      dsh     = NW'(len_ff) << k_ff;
      div_ge  = (rem_ff >= dsh);
      q_nx    = div_ge ? (q_ff | (QW'(1) << k_ff)) : q_ff;
      q_signed = neg_ff[j_ff] ? -AW'({1'b0, q_nx}) : AW'({1'b0, q_nx});
   end

   assign sq_last  = ph_ff && (j_ff == 2'd2);
   assign x_last   = ph_ff && (c_ff == 2'd2) && (j_ff == 2'd1);
   assign dot_last = ph_ff && (c_ff == 2'd2) && (j_ff == 2'd2);

   // Select multiplier operands
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         xa[i] = '0;
         xb[i] = '0;
      end
      if (state_ff == ST_X1) begin
         xa[0] = 33'($signed(up_x));
         xa[1] = 33'($signed(up_y));
         xa[2] = 33'($signed(up_z));
         for (int i = 0; i < 3; i++) xb[i] = ax33(axis_ff[2][i]);
      end else begin
         for (int i = 0; i < 3; i++) begin
            xa[i] = ax33(axis_ff[2][i]);
            xb[i] = ax33(axis_ff[0][i]);
         end
      end
      case (c_ff)
         2'd0:    for (int i = 0; i < 3; i++) ra[i] = ax33(axis_ff[0][i]);
         2'd1:    for (int i = 0; i < 3; i++) ra[i] = ax33(axis_ff[1][i]);
         default: for (int i = 0; i < 3; i++) ra[i] = ax33(axis_ff[2][i]);
      endcase
      opa = '0;
      opb = '0;
      case (state_ff)
         ST_SQ: begin
            opa = $signed({3'b000, mag_ff[j_ff][29:0]});
            opb = opa;
         end
         ST_X1, ST_X2: begin
            case ({c_ff, j_ff[0]})
               3'b000:  begin opa = xa[1]; opb = xb[2]; end
               3'b001:  begin opa = xa[2]; opb = xb[1]; end
               3'b010:  begin opa = xa[2]; opb = xb[0]; end
               3'b011:  begin opa = xa[0]; opb = xb[2]; end
               3'b100:  begin opa = xa[0]; opb = xb[1]; end
               default: begin opa = xa[1]; opb = xb[0]; end
            endcase
         end
         ST_DOT: begin
            case (j_ff)
               2'd0:    begin opa = 33'($signed(eye_ff[0])); opb = ra[0]; end
               2'd1:    begin opa = 33'($signed(eye_ff[1])); opb = ra[1]; end
               default: begin opa = 33'($signed(eye_ff[2])); opb = ra[2]; end
            endcase
         end
         default: ;
      endcase
   end

   // Round the negated dot products and saturate
   always_comb begin
      logic signed [DW-1:0] t;
      logic signed [DW-1:0] r;
      for (int i = 0; i < 3; i++) begin
         t = -dot_ff[i] + (DW'(1) << (FRAC_BITS - 1));
         r = t >>> FRAC_BITS;
         if ((&r[DW-1:31]) || !(|r[DW-1:31])) begin
            trans[i] = r[31:0];
         end else begin
            trans[i] = r[DW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
         end
      end
   end

   // Where a finished normalization leads
   always_comb begin
      unique case (tgt_ff)
         2'd2:    after_norm = ST_X1;
         2'd0:    after_norm = ST_X2;
         default: after_norm = ST_DOT;
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (job_valid) state_in = ST_ABS;
         ST_ABS:   state_in = vec_zero ? after_norm : ST_SCALE;
         ST_SCALE: if (in_range) state_in = ST_SQ;
         ST_SQ:    if (sq_last) state_in = ST_SQRT;
         ST_SQRT:  if (bit_ff[0]) state_in = ST_DLD;
         ST_DLD:   state_in = ST_DIV;
         ST_DIV: begin
            if (k_ff == '0) state_in = (j_ff == 2'd2) ? after_norm : ST_DLD;
         end
         ST_X1, ST_X2: if (x_last) state_in = ST_ABS;
         ST_DOT:   if (dot_last) state_in = ST_FIN;
         ST_FIN:   if (mat_ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      job_pop   = 1'b0;
      mat_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: job_pop   = job_valid;
         ST_FIN:  mat_valid = 1'b1;
         default: ;
      endcase
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int r = 0; r < 3; r++) begin
            mat.row[r][i] = 32'(axis_ff[r][i]);
         end
         mat.row[3][i] = trans[i];
      end
      mat.deg = deg_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            tgt_ff <= 2'd2;
            deg_ff <= 1'b0;
            for (int i = 0; i < 3; i++) begin
               eye_ff[i] <= job.eye[i];
               vec_ff[i] <= VW'($signed(job.diff[i]));
            end
         end
         ST_ABS: begin
            for (int i = 0; i < 3; i++) begin
               mag_ff[i] <= vec_ff[i][VW-1] ? VW'(-vec_ff[i]) : VW'(vec_ff[i]);
               neg_ff[i] <= vec_ff[i][VW-1];
            end
            if (vec_zero) begin
               deg_ff <= 1'b1;
               for (int i = 0; i < 3; i++) begin
                  axis_ff[tgt_ff][i] <= '0;
                  dot_ff[i]          <= '0;
               end
               c_ff  <= 2'd0;
               j_ff  <= 2'd0;
               ph_ff <= 1'b0;
            end
         end
         ST_SCALE: begin
            for (int i = 0; i < 3; i++) begin
               if (hi8)      mag_ff[i] <= mag_ff[i] >> 8;
               else if (hi1) mag_ff[i] <= mag_ff[i] >> 1;
               else if (lo8) mag_ff[i] <= mag_ff[i] << 8;
               else if (lo1) mag_ff[i] <= mag_ff[i] << 1;
            end
            sum_ff <= '0;
            j_ff   <= 2'd0;
            ph_ff  <= 1'b0;
         end
         ST_SQ: begin
            ph_ff <= ~ph_ff;
            if (!ph_ff) begin
               prod_ff <= opa * opb;
            end else begin
               sum_ff <= sum_ff + prod_ff[SW-1:0];
               j_ff   <= j_ff + 2'd1;
            end
            root_ff <= '0;
            bit_ff  <= SW'(1) << 60;
         end
         ST_SQRT: begin
            if (sq_ge) sum_ff <= sum_ff - sq_t;
            root_ff <= root_nx;
            bit_ff  <= bit_ff >> 2;
            len_ff  <= root_nx[30:0];
            j_ff    <= 2'd0;
         end
         ST_DLD: begin
            rem_ff <= (NW'(mag_ff[j_ff][29:0]) << FRAC_BITS) + NW'(len_ff >> 1);
            q_ff   <= '0;
            k_ff   <= KW'(FRAC_BITS);
         end
         ST_DIV: begin
            if (div_ge) rem_ff <= rem_ff - dsh;
            q_ff <= q_nx;
            k_ff <= k_ff - KW'(1);
            if (k_ff == '0) begin
               axis_ff[tgt_ff][j_ff] <= q_signed;
               j_ff <= (j_ff == 2'd2) ? 2'd0 : j_ff + 2'd1;
               if (j_ff == 2'd2) begin
                  for (int i = 0; i < 3; i++) begin
                     vec_ff[i] <= '0;
                     dot_ff[i] <= '0;
                  end
                  c_ff  <= 2'd0;
                  ph_ff <= 1'b0;
               end
            end
         end
         ST_X1, ST_X2: begin
            ph_ff <= ~ph_ff;
            if (!ph_ff) begin
               prod_ff <= opa * opb;
            end else begin
               vec_ff[c_ff] <= j_ff[0] ? vec_ff[c_ff] - prod_ff[VW-1:0]
                                       : vec_ff[c_ff] + prod_ff[VW-1:0];
               j_ff <= j_ff[0] ? 2'd0 : 2'd1;
               if (j_ff[0]) c_ff <= c_ff + 2'd1;
            end
            tgt_ff <= (state_ff == ST_X1) ? 2'd0 : 2'd1;
         end
         ST_DOT: begin
            ph_ff <= ~ph_ff;
            if (!ph_ff) begin
               prod_ff <= opa * opb;
            end else begin
               dot_ff[c_ff] <= dot_ff[c_ff] + prod_ff[DW-1:0];
               j_ff <= (j_ff == 2'd2) ? 2'd0 : j_ff + 2'd1;
               if (j_ff == 2'd2) c_ff <= c_ff + 2'd1;
            end
         end
         ST_FIN: ;
         default: ;
      endcase
   end

endmodule

`default_nettype wire

>>> hdl/lavm_out.sv
`timescale 1ns / 1ps
`default_nettype none

module lavm_out (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            mat_valid,
   output logic                                 mat_ready,
   input  wire lavm_pkg::matrix_type            mat,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [lavm_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic [lavm_pkg::RSP_USER_W-1:0]      rsp_tuser,
   output logic                                 rsp_tlast
);
   import lavm_pkg::*;

   matrix_type mat_ff;
   logic       busy_ff;
   logic [1:0] cnt_ff;
   logic       xfer;

   assign mat_ready  = !busy_ff;
   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = {mat_ff.row[cnt_ff][2], mat_ff.row[cnt_ff][1], mat_ff.row[cnt_ff][0]};
   assign rsp_tuser  = {mat_ff.deg, cnt_ff};
   assign rsp_tlast  = (cnt_ff == ROW_TRANS);
   assign xfer       = rsp_tvalid && rsp_tready;

   // Hold the matrix while its rows drain
   always_ff @(posedge clock) begin
      if (mat_valid && mat_ready) begin
         mat_ff <= mat;
      end
   end

   // Step through the four rows
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= ROW_RIGHT;
      end else if (mat_valid && mat_ready) begin
         busy_ff <= 1'b1;
         cnt_ff  <= ROW_RIGHT;
      end else if (xfer) begin
         cnt_ff <= cnt_ff + 2'd1;
         if (rsp_tlast) busy_ff <= 1'b0;
      end
   end

endmodule

`default_nettype wire

>>> hdl/look_at_view_matrix.sv
// Channel  Direction  Payload
// req_     in         tdata: eye_x, eye_y, eye_z, target_x, target_y, target_z
// rsp_     out        tdata: elem_x, elem_y, elem_z; tuser: row_index, degenerate;
//                     tlast: last_row
// csr_     in         index 0 up_x, 1 up_y, 2 up_z; other indexes ignored
//
// In the core at FRAC_BITS 16, each of the three normalizations runs 1 to 9
// scaling steps, a 31-step bit-serial square root and a restoring divider for
// each component. A zero vector skips its normalization.
// A two-entry queue takes items while the core works; a row buffer lets the
// core start the next item while four rows drain, one per transfer.
// Reset is synchronous; it empties the queue and the row buffer and sets the
// up vector to (0, 1.0, 0).
`timescale 1ns / 1ps
`default_nettype none

module look_at_view_matrix #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // eye_x, eye_y, eye_z, target_x, target_y, target_z
   input  wire logic [lavm_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // elem_x, elem_y, elem_z
   output logic [lavm_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // row_index[1:0], degenerate
   output logic [lavm_pkg::RSP_USER_W-1:0]      rsp_tuser,
   output logic                                 rsp_tlast,
   input  wire logic                            csr_wen,
   input  wire logic [lavm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [lavm_pkg::WORD_W-1:0]     csr_wdata
);
   import lavm_pkg::*;

   logic [WORD_W-1:0] up_x_ff, up_y_ff, up_z_ff;
   logic              job_valid, job_pop, mat_valid, mat_ready;
   job_type           job;
   matrix_type        mat;

   // Decode configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         up_x_ff <= UP_X_RESET;
         up_y_ff <= UP_Y_RESET;
         up_z_ff <= UP_Z_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_UP_X: up_x_ff <= csr_wdata;
            CSR_UP_Y: up_y_ff <= csr_wdata;
            CSR_UP_Z: up_z_ff <= csr_wdata;
            default:  ;
         endcase
      end
   end

   lavm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .job_valid  (job_valid),
      .job_pop    (job_pop),
      .job        (job)
   );

   lavm_core #(
      .FRAC_BITS (FRAC_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_pop   (job_pop),
      .job       (job),
      .up_x      (up_x_ff),
      .up_y      (up_y_ff),
      .up_z      (up_z_ff),
      .mat_valid (mat_valid),
      .mat_ready (mat_ready),
      .mat       (mat)
   );

   lavm_out u_out (
      .clock      (clock),
      .reset      (reset),
      .mat_valid  (mat_valid),
      .mat_ready  (mat_ready),
      .mat        (mat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Rows of one matrix come in order
   a_row_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=>
         (rsp_tvalid && (rsp_tuser[1:0] == $past(rsp_tuser[1:0]) + 2'd1)))
      else $error("row index did not advance");

   // The degenerate flag is the same on every row of a matrix
   a_deg_same: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> (rsp_tuser[2] == $past(rsp_tuser[2])))
      else $error("degenerate flag changed inside a matrix");

   // rsp_tvalid drops once the last row of a matrix has been taken
   a_new_mat: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> !rsp_tvalid)
      else $error("row buffer reloaded before last row left");

endmodule

`default_nettype wire
